// ----- sv/outstanding_request_tracker_macros.svh -----
// Assertion macros for the outstanding request tracker.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef OUTSTANDING_REQUEST_TRACKER_MACROS_SVH
`define OUTSTANDING_REQUEST_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ORT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("outstanding_request_tracker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ORT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("outstanding_request_tracker: next-cycle check failed");

`else

`define ORT_ASSERT_SAME(label, ante, cons)
`define ORT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- sv/ort_pkg.sv -----
package ort_pkg;

  // Default configuration.
  localparam int TABLE_DEPTH_DEFAULT = 16;
  localparam int DIGEST_BITS_DEFAULT = 64;

  // Operation codes on the op input.
  localparam logic OP_RECORD  = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  // Result status codes.
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                scan_step;
    logic                clear_hit;
    logic                write_entry;
    logic                finish;
    logic [STATUS_W-1:0] result_code;
  } ort_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;
    logic consume;
    logic hit;
    logic reads_done;
    logic cmp_pending;
  } ort_stat_t;

endpackage

// ----- sv/ort_ram.sv -----
module ort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/ort_dp.sv -----
module ort_dp #(
  parameter int TABLE_DEPTH = ort_pkg::TABLE_DEPTH_DEFAULT,
  parameter int DIGEST_BITS = ort_pkg::DIGEST_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ort_pkg::ort_cmd_t             cmd,
  output ort_pkg::ort_stat_t            stat,
  input  logic                          op,
  input  logic [31:0]                   src_addr,
  input  logic [31:0]                   dst_addr,
  input  logic [15:0]                   identifier,
  input  logic [15:0]                   sequence_number,
  input  logic [15:0]                   echo_len,
  input  logic [63:0]                   echo_digest,
  input  logic [7:0]                    icmp_type,
  input  logic [7:0]                    icmp_code,
  output logic                          strobe,
  output logic [ort_pkg::STATUS_W-1:0]  status
);

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = 32 + 32 + 16 + 16 + 16 + DIGEST_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  logic                   op_q;
  logic                   reject_q;
  logic [ENTRY_W-1:0]     key_q;
  logic [TABLE_DEPTH-1:0] valid;
  logic [IDX_W-1:0]       wp;
  logic [IDX_W-1:0]       rd_addr;
  logic [CNT_W-1:0]       rd_count;
  logic [IDX_W-1:0]       cmp_addr;
  logic                   cmp_vld;
  logic [ENTRY_W-1:0]     ram_q;
  logic                   hit;
  logic                   bad_item;
  logic [IDX_W-1:0]       newest_idx;
  logic [IDX_W-1:0]       rd_addr_next;

  // A record needs a nonzero length; a consume also needs an echo reply with code zero.
  assign bad_item = (echo_len == 16'd0) ||
                    ((op == ort_pkg::OP_CONSUME) &&
                     ((icmp_type != 8'd0) || (icmp_code != 8'd0)));

  assign newest_idx = (wp == '0) ? LAST_IDX : wp - IDX_W'(1);

  // Records sweep oldest-agnostic upward; consumes walk from newest to oldest.
  always_comb begin
    if (op_q == ort_pkg::OP_CONSUME) begin
      rd_addr_next = (rd_addr == '0) ? LAST_IDX : rd_addr - IDX_W'(1);
    end else begin
      rd_addr_next = (rd_addr == LAST_IDX) ? '0 : rd_addr + IDX_W'(1);
    end
  end

  assign hit = cmp_vld && valid[cmp_addr] && (ram_q == key_q);

  assign stat.reject      = reject_q;
  assign stat.consume     = (op_q == ort_pkg::OP_CONSUME);
  assign stat.hit         = hit;
  assign stat.reads_done  = (rd_count == FULL_COUNT);
  assign stat.cmp_pending = cmp_vld;

  ort_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.write_entry),
    .wr_addr (wp),
    .wr_data (key_q),
    .rd_en   (cmd.scan_step),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Item capture and scan pointers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op;
      reject_q <= bad_item;
      key_q    <= {src_addr, dst_addr, identifier, sequence_number,
                   echo_len, echo_digest[DIGEST_BITS-1:0]};
      rd_addr  <= (op == ort_pkg::OP_CONSUME) ? newest_idx : '0;
      rd_count <= '0;
    end else if (cmd.scan_step) begin
      rd_addr  <= rd_addr_next;
      rd_count <= rd_count + CNT_W'(1);
    end
    if (cmd.scan_step) begin
      cmp_addr <= rd_addr;
    end
  end

  // Control state: valid bits, write pointer, compare slot and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      wp      <= '0;
      cmp_vld <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_step;
      strobe  <= cmd.finish;
      if (cmd.clear_hit && hit) begin
        valid[cmp_addr] <= 1'b0;
      end
      if (cmd.write_entry) begin
        valid[wp] <= 1'b1;
        wp        <= (wp == LAST_IDX) ? '0 : wp + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= cmd.result_code;
    end
  end

endmodule

// ----- sv/ort_ctrl.sv -----
module ort_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ort_pkg::ort_stat_t  stat,
  output ort_pkg::ort_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.result_code = ort_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.reject) begin
          cmd.finish      = 1'b1;
          cmd.result_code = ort_pkg::ST_REJECT;
          state_next      = S_IDLE;
        end else if (stat.consume && stat.hit) begin
          // The newest matching entry is retired and the search stops.
          cmd.clear_hit   = 1'b1;
          cmd.finish      = 1'b1;
          cmd.result_code = ort_pkg::ST_OK;
          state_next      = S_IDLE;
        end else if (stat.reads_done && !stat.cmp_pending) begin
          if (stat.consume) begin
            cmd.finish      = 1'b1;
            cmd.result_code = ort_pkg::ST_MISS;
            state_next      = S_IDLE;
          end else begin
            state_next = S_WRITE;
          end
        end else begin
          cmd.clear_hit = 1'b1;
          cmd.scan_step = !stat.reads_done;
        end
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        cmd.finish      = 1'b1;
        cmd.result_code = ort_pkg::ST_OK;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/outstanding_request_tracker.sv -----
// Outstanding echo request tracker. An item is transferred in at a rising edge where
// start is high and busy is low; its single result appears on status for exactly one
// cycle, marked by strobe, and the receiver cannot stall it, so it must take the
// transfer in that cycle. A record (op 0) clears any older entry with the same
// identity and then writes the ring slot at the write pointer, overwriting it; a
// consume (op 1) retires the newest matching entry. Status 0 means recorded or
// matched, 1 means rejected (zero length, or a consume that is not an echo reply
// with code zero), 2 means no matching entry. Entries live in a single-port-read RAM
// that is scanned one entry per cycle, and that scan sets the latency. A record
// takes a full scan, a compare of the last entry, a step that closes the scan and a
// write of the slot before strobe; an unmatched consume takes the full scan, the last
// compare and the closing step; a consume that hits stops at the compare of the
// matching entry; a rejected item is finished before any entry is compared.
// Busy drops in the cycle that strobe is shown, so the next item can be transferred
// in that same cycle. Valid bits reset to empty at once; no clearing pass is needed.
`include "outstanding_request_tracker_macros.svh"

module outstanding_request_tracker #(
  parameter int TABLE_DEPTH = ort_pkg::TABLE_DEPTH_DEFAULT,
  parameter int DIGEST_BITS = ort_pkg::DIGEST_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [31:0]                   src_addr,
  input  logic [31:0]                   dst_addr,
  input  logic [15:0]                   identifier,
  input  logic [15:0]                   sequence_number,
  input  logic [15:0]                   echo_len,
  input  logic [63:0]                   echo_digest,
  input  logic [7:0]                    icmp_type,
  input  logic [7:0]                    icmp_code,
  output logic                          strobe,
  output logic [ort_pkg::STATUS_W-1:0]  status
);

  // The controller sequences the scan; the datapath holds the table and the item.
  ort_pkg::ort_cmd_t  cmd;
  ort_pkg::ort_stat_t stat;

  ort_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ort_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DIGEST_BITS (DIGEST_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .op              (op),
    .src_addr        (src_addr),
    .dst_addr        (dst_addr),
    .identifier      (identifier),
    .sequence_number (sequence_number),
    .echo_len        (echo_len),
    .echo_digest     (echo_digest),
    .icmp_type       (icmp_type),
    .icmp_code       (icmp_code),
    .strobe          (strobe),
    .status          (status)
  );

  // A result is only shown once the controller is back to idle.
  `ORT_ASSERT_SAME(a_strobe_when_idle, strobe, !busy)
  // An accepted item always makes the block busy in the cycle after it is taken.
  `ORT_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  // No result can appear in the cycle right after a transfer in.
  `ORT_ASSERT_NEXT(a_no_instant_result, start && !busy, !strobe)
  // Only the three defined status codes are ever reported.
  `ORT_ASSERT_SAME(a_status_legal, strobe,
    (status == ort_pkg::ST_OK) || (status == ort_pkg::ST_REJECT) ||
    (status == ort_pkg::ST_MISS))

endmodule
